// File: hw/rtl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg: shared types and constants of the Bezier curve sampler
// Curve codes, fixed-point widths, sequencer states and the t rounding helper.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int MAX_SAMPLES_DEF = 64;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int SPC_W     = 7;
  localparam int SPC_RESET = 10;

  localparam int FRAC  = 16;
  localparam int TW    = FRAC + 1;
  localparam int HALF  = 1 << (FRAC - 1);
  localparam int T_ONE = 1 << FRAC;

  localparam logic [1:0] FUNC_CUBIC = 2'd0;
  localparam logic [1:0] FUNC_QUAD  = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COEF,
    ST_COEF2,
    ST_DIV,
    ST_TT,
    ST_CX,
    ST_T3,
    ST_BX,
    ST_AX,
    ST_CY,
    ST_BY,
    ST_AY,
    ST_ACC,
    ST_PT,
    ST_EMIT
  } bcs_state_t;

  function automatic logic [TW-1:0] t_round(input logic [2*TW-1:0] p);
    logic [2*TW-1:0] sum;
    sum = p + (2*TW)'(HALF);
    return sum[FRAC+TW-1:FRAC];
  endfunction

endpackage

// File: hw/rtl/bcs_div.sv
// ----------------------------------------------------------------------------
// bcs_div: radix-2 restoring divider
// One quotient bit per cycle; used once per curve to form the t increment.
// ----------------------------------------------------------------------------
module bcs_div #(
  parameter int NW = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [bcs_pkg::TW-1:0] dividend,
  input  logic [NW-1:0]          divisor,
  output logic                   done,
  output logic [bcs_pkg::TW-1:0] quotient
);
  import bcs_pkg::*;

  localparam int CNTW = $clog2(TW + 1);

  logic [TW-1:0]   quo_r;
  logic [NW-1:0]   rem_r;
  logic [NW-1:0]   div_r;
  logic [CNTW-1:0] cnt_r;
  logic            done_r;
  logic [NW:0]     shifted;
  logic            ge;
  logic [NW:0]     diff;

  always_comb begin
    shifted = {rem_r, quo_r[TW-1]};
    diff    = shifted - {1'b0, div_r};
    ge      = shifted >= {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNTW'(TW);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CNTW'(1);
      done_r <= (cnt_r == CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[TW-2:0], ge};
      rem_r <= ge ? diff[NW-1:0] : shifted[NW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hw/rtl/bcs_mul.sv
// ----------------------------------------------------------------------------
// bcs_mul: shared signed-by-unsigned multiplier
// Coefficient or t value times a Q1.16 t power, product registered.
// ----------------------------------------------------------------------------
module bcs_mul #(
  parameter int AW = 36
) (
  input  logic                           clk,
  input  logic signed [AW-1:0]           op_a,
  input  logic        [bcs_pkg::TW-1:0]  op_b,
  output logic signed [AW+bcs_pkg::TW:0] prod
);
  import bcs_pkg::*;

  logic signed [AW+TW:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * $signed({1'b0, op_b});
  end

  assign prod = prod_r;

endmodule

// File: hw/rtl/bezier_curve_sampler.sv
// ----------------------------------------------------------------------------
// bezier_curve_sampler: power-form Bezier curve sampler
// A curve word given with start is sampled at samples_per_curve equally spaced
// values of t (the count clamped to 2..MAX_SAMPLES). One multiplier is shared
// by all products: each sample takes eight dependent products plus rounding and
// output, and a curve first sets up the coefficients and runs the serial divide
// of the t increment. Curve types other than cubic and quadratic are taken and
// dropped at once. Each sample is shown for one cycle with out_valid; the
// receiver cannot stall.
// ----------------------------------------------------------------------------
module bezier_curve_sampler #(
  parameter int MAX_SAMPLES = bcs_pkg::MAX_SAMPLES_DEF,
  parameter int COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_first_ctrl_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_ctrl_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_ctrl_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_ctrl_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_point_x,
  output logic signed [COORD_WIDTH-1:0] out_point_y,
  output logic                          out_fresh,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bcs_pkg::SPC_W-1:0]     cfg_samples_per_curve
);
  import bcs_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = CW + 4;
  localparam int PW   = AW + TW + 1;
  localparam int ACW  = CW + FRAC;
  localparam int NW   = $clog2(MAX_SAMPLES + 1);
  localparam int CMPW = (NW > SPC_W) ? NW : SPC_W;

  bcs_state_t state_r, state_nxt;

  logic [SPC_W-1:0] spc_r;
  logic [CMPW-1:0]  spc_c;
  logic [NW-1:0]    n_c;
  logic [NW-1:0]    nm1_c;
  logic [TW-1:0]    dividend_c;
  logic             go;
  logic             div_start;
  logic             div_done;
  logic [TW-1:0]    inc;

  logic [NW-1:0]    n_r;
  logic [NW-1:0]    i_r;
  logic             quad_r;
  logic [TW-1:0]    t_r;
  logic [TW-1:0]    t2_r;
  logic [TW-1:0]    t3_r;

  logic signed [CW-1:0]  s_r   [2];
  logic signed [CW-1:0]  a_r   [2];
  logic signed [CW-1:0]  b_r   [2];
  logic signed [CW-1:0]  e_r   [2];
  logic signed [CW:0]    d0_r  [2];
  logic signed [CW:0]    d1_r  [2];
  logic signed [CW:0]    d2_r  [2];
  logic signed [AW-1:0]  ca_r  [2];
  logic signed [AW-1:0]  cb_r  [2];
  logic signed [AW-1:0]  cc_r  [2];
  logic [ACW-1:0]        acc_r [2];
  logic [CW-1:0]         pt_r  [2];
  logic [CW-1:0]         prev_r[2];

  logic signed [AW-1:0] mul_a;
  logic [TW-1:0]        mul_b;
  logic signed [PW-1:0] prod;
  logic [ACW-1:0]       prod_lo;
  logic [TW-1:0]        prod_t;

  logic            out_valid_r;
  logic [CW-1:0]   out_x_r;
  logic [CW-1:0]   out_y_r;
  logic            out_fresh_r;
  logic            out_last_r;
  logic            fresh_c;

  // clamp sample count and form the rounded-increment dividend
  always_comb begin
    spc_c = CMPW'(spc_r);
    if (spc_c < CMPW'(2)) begin
      n_c = NW'(2);
    end else if (spc_c > CMPW'(MAX_SAMPLES)) begin
      n_c = NW'(MAX_SAMPLES);
    end else begin
      n_c = NW'(spc_c);
    end
    nm1_c      = n_c - NW'(1);
    dividend_c = TW'(T_ONE) + TW'(nm1_c >> 1);
  end

  assign go        = start && !busy &&
                     (in_func == FUNC_CUBIC || in_func == FUNC_QUAD);
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r <= SPC_W'(SPC_RESET);
    end else if (cfg_valid && cfg_ready) begin
      spc_r <= cfg_samples_per_curve;
    end
  end

  bcs_div #(.NW(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend_c),
    .divisor  (nm1_c),
    .done     (div_done),
    .quotient (inc)
  );

  bcs_mul #(.AW(AW)) u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign prod_lo = prod[ACW-1:0];
  assign prod_t  = t_round(prod[2*TW-1:0]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (go) state_nxt = ST_COEF;
      ST_COEF:  state_nxt = ST_COEF2;
      ST_COEF2: state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_TT;
      ST_TT:    state_nxt = ST_CX;
      ST_CX:    state_nxt = ST_T3;
      ST_T3:    state_nxt = ST_BX;
      ST_BX:    state_nxt = ST_AX;
      ST_AX:    state_nxt = ST_CY;
      ST_CY:    state_nxt = ST_BY;
      ST_BY:    state_nxt = ST_AY;
      ST_AY:    state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_PT;
      ST_PT:    state_nxt = ST_EMIT;
      ST_EMIT:  state_nxt = (i_r == n_r - NW'(1)) ? ST_IDLE : ST_TT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, divider kick, busy
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: div_start = go;
      ST_TT: begin
        mul_a = AW'(t_r);
        mul_b = t_r;
      end
      ST_CX: begin
        mul_a = cc_r[0];
        mul_b = t_r;
      end
      ST_T3: begin
        mul_a = AW'(t2_r);
        mul_b = t_r;
      end
      ST_BX: begin
        mul_a = cb_r[0];
        mul_b = t2_r;
      end
      ST_AX: begin
        mul_a = ca_r[0];
        mul_b = t3_r;
      end
      ST_CY: begin
        mul_a = cc_r[1];
        mul_b = t_r;
      end
      ST_BY: begin
        mul_a = cb_r[1];
        mul_b = t2_r;
      end
      ST_AY: begin
        mul_a = ca_r[1];
        mul_b = t3_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign fresh_c = (pt_r[0] != prev_r[0]) || (pt_r[1] != prev_r[1]);

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (go) begin
          s_r[0]    <= in_start_x;
          s_r[1]    <= in_start_y;
          a_r[0]    <= in_first_ctrl_x;
          a_r[1]    <= in_first_ctrl_y;
          b_r[0]    <= in_second_ctrl_x;
          b_r[1]    <= in_second_ctrl_y;
          e_r[0]    <= in_end_x;
          e_r[1]    <= in_end_y;
          prev_r[0] <= in_start_x;
          prev_r[1] <= in_start_y;
          quad_r    <= (in_func == FUNC_QUAD);
          n_r       <= n_c;
          i_r       <= '0;
          t_r       <= '0;
        end
      end
      ST_COEF: begin
        for (int k = 0; k < 2; k++) begin
          d0_r[k] <= quad_r ? ((CW+1)'(b_r[k]) - (CW+1)'(s_r[k]))
                            : ((CW+1)'(a_r[k]) - (CW+1)'(s_r[k]));
          d1_r[k] <= (CW+1)'(b_r[k]) - (CW+1)'(a_r[k]);
          d2_r[k] <= (CW+1)'(e_r[k]) - (CW+1)'(b_r[k]);
        end
      end
      ST_COEF2: begin
        for (int k = 0; k < 2; k++) begin
          if (quad_r) begin
            cc_r[k] <= AW'(d0_r[k]) <<< 1;
            cb_r[k] <= AW'(d2_r[k]) - AW'(d0_r[k]);
            ca_r[k] <= '0;
          end else begin
            cc_r[k] <= AW'(d0_r[k]) + (AW'(d0_r[k]) <<< 1);
            cb_r[k] <= (AW'(d1_r[k]) - AW'(d0_r[k])) +
                       ((AW'(d1_r[k]) - AW'(d0_r[k])) <<< 1);
            ca_r[k] <= AW'(d2_r[k]) - (AW'(d1_r[k]) <<< 1) + AW'(d0_r[k]);
          end
        end
      end
      ST_CX:  t2_r     <= prod_t;
      ST_T3:  acc_r[0] <= prod_lo;
      ST_BX:  t3_r     <= prod_t;
      ST_AX:  acc_r[0] <= acc_r[0] + prod_lo;
      ST_CY:  acc_r[0] <= acc_r[0] + prod_lo;
      ST_BY:  acc_r[1] <= prod_lo;
      ST_AY:  acc_r[1] <= acc_r[1] + prod_lo;
      ST_ACC: acc_r[1] <= acc_r[1] + prod_lo;
      ST_PT: begin
        for (int k = 0; k < 2; k++) begin
          pt_r[k] <= s_r[k] + CW'((acc_r[k] + ACW'(HALF)) >> FRAC);
        end
      end
      ST_EMIT: begin
        if (fresh_c) begin
          prev_r[0] <= pt_r[0];
          prev_r[1] <= pt_r[1];
        end
        i_r <= i_r + NW'(1);
        t_r <= t_r + inc;
      end
      default: begin
      end
    endcase
  end

  // result word, shown for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT) begin
      out_x_r     <= pt_r[0];
      out_y_r     <= pt_r[1];
      out_fresh_r <= fresh_c;
      out_last_r  <= (i_r == n_r - NW'(1));
    end
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = out_x_r;
  assign out_point_y = out_y_r;
  assign out_fresh   = out_fresh_r;
  assign out_last    = out_last_r;

endmodule

// File: hw/rtl/bcs_checker.sv
// ----------------------------------------------------------------------------
// bcs_checker: port-level checks for the Bezier curve sampler
// Watches the command and result ports; bound to the top level below.
// ----------------------------------------------------------------------------
module bcs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_last
);
  import bcs_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("outputs active after reset");

  a_curve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_func == FUNC_CUBIC || in_func == FUNC_QUAD) |=> busy)
    else $error("curve word taken but block not busy");

  a_drop_none: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func != FUNC_CUBIC && in_func != FUNC_QUAD |=> !busy)
    else $error("empty curve word held the block");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy ##1 !out_valid)
    else $error("inner sample not followed by further work");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("block still busy after final sample");

endmodule

bind bezier_curve_sampler bcs_checker u_bcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_func   (in_func),
  .out_valid (out_valid),
  .out_last  (out_last)
);
